>>> design/mbdp_pkg.sv
package mbdp_pkg;

  localparam int ROW_BYTES_DEF = 16;
  localparam int STORED_ROWS   = 7;
  localparam int PAGE_ROWS     = 8;
  localparam int PIX_PER_BYTE  = 8;

  localparam logic [2:0] LAST_ROW     = 3'd7;
  localparam logic [2:0] LAST_COLUMN  = 3'd7;
  localparam logic       INVERT_RESET = 1'b1;

  typedef struct packed {
    logic [2:0] row_in_page;
    logic [3:0] byte_index;
    logic [7:0] pixel_byte;
  } mbdp_in_t;

  typedef struct packed {
    logic [6:0] column_index;
    logic [7:0] page_byte;
    logic       last_of_group;
    logic       last_of_page;
  } mbdp_out_t;

  // One column group of a page: raw pixel bytes of all eight rows.
  typedef struct packed {
    logic [3:0]                      byte_index;
    logic                            last_group;
    logic [PAGE_ROWS-1:0][7:0]       rows;
  } mbdp_group_t;

endpackage

>>> design/mbdp_row_bank.sv
module mbdp_row_bank import mbdp_pkg::*; #(
  parameter int DEPTH = ROW_BYTES_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/mbdp_burst.sv
module mbdp_burst import mbdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        invert,
  input  logic        load_valid,
  output logic        load_ready,
  input  mbdp_group_t load_group,
  output logic        out_valid,
  input  logic        out_stall,
  output mbdp_out_t   out_data
);

  logic                          busy_r, busy_nxt;
  logic [2:0]                    k_r, k_nxt;
  logic [3:0]                    col_r;
  logic                          last_grp_r;
  logic [PIX_PER_BYTE-1:0][7:0]  pages_r;
  logic [PIX_PER_BYTE-1:0][7:0]  pages_load;
  logic                          take;
  logic                          last;
  logic                          load;

  assign take       = busy_r && !out_stall;
  assign last       = (k_r == LAST_COLUMN);
  assign load_ready = !busy_r || (take && last);
  assign load       = load_valid && load_ready;

  // Transpose: column k (leftmost first) takes bit 7-k of every row, XOR invert.
  always_comb begin
    for (int k = 0; k < PIX_PER_BYTE; k++) begin
      for (int r = 0; r < PAGE_ROWS; r++) begin
        pages_load[k][r] = load_group.rows[r][PIX_PER_BYTE-1-k] ^ invert;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (load) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (take) begin
      k_nxt = k_r + 3'd1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pages_r    <= pages_load;
      col_r      <= load_group.byte_index;
      last_grp_r <= load_group.last_group;
    end else if (take) begin
      pages_r <= {8'h00, pages_r[PIX_PER_BYTE-1:1]};
    end
  end

  assign out_valid              = busy_r;
  assign out_data.column_index  = {col_r, k_r};
  assign out_data.page_byte     = pages_r[0];
  assign out_data.last_of_group = last;
  assign out_data.last_of_page  = last && last_grp_r;

`ifndef NO_ASSERTIONS
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_stall && !last |=> busy_r && k_r == $past(k_r) + 3'd1)
    else $error("burst dropped before its eighth column");
  a_stall_holds_col: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_stall |=> busy_r && $stable(k_r) && $stable(col_r))
    else $error("stalled burst advanced");
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy_r && k_r == 3'd0)
    else $error("loaded group did not start at column zero");
`endif

endmodule

>>> design/mono_bitmap_to_display_pages.sv
// Transposes a 1-bpp row-major bitmap into vertical page bytes, one 8-row page
// at a time. Pixel bytes of rows 0 to 6 are written into seven row banks of
// ROW_BYTES bytes each and produce nothing; the row-7 byte of a column group
// reads the seven stored bytes in the cycle it is taken; the group then waits
// in a one-deep stage until the burst transposes it into eight page bytes
// that leave one per cycle unless out_stall holds them, leftmost column first.
// Items are taken one per cycle while in_stall is low; a row-7 request holds
// the output for its eight page bytes, the next one waits in the stage, and
// while the stage cannot drain the input takes no bytes of any row. Bytes with
// byte_index at or beyond ROW_BYTES are dropped. The invert setting applies
// when a group is transposed and may be written only while the block is idle.
module mono_bitmap_to_display_pages import mbdp_pkg::*; #(
  parameter int ROW_BYTES = ROW_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mbdp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mbdp_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int AW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  logic                         invert_r;
  logic                         s1_valid_r, s1_valid_nxt;
  logic [3:0]                   s1_col_r;
  logic [7:0]                   s1_pix_r;
  logic [STORED_ROWS-1:0][7:0]  rd_data;
  logic                         in_acc;
  logic                         in_range;
  logic                         is_last_row;
  logic                         rd_en;
  logic                         load_ready;
  logic                         s1_adv;
  mbdp_group_t                  group;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= INVERT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      invert_r <= cfg_data;
    end
  end

  assign in_range    = ({1'b0, in_data.byte_index} < 5'(ROW_BYTES));
  assign is_last_row = (in_data.row_in_page == LAST_ROW);
  assign s1_adv      = s1_valid_r && load_ready;
  assign in_stall    = s1_valid_r && !load_ready;
  assign in_acc      = in_valid && !in_stall;
  assign rd_en       = in_acc && in_range && is_last_row;

  for (genvar r = 0; r < STORED_ROWS; r++) begin : g_bank
    mbdp_row_bank #(
      .DEPTH (ROW_BYTES),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (in_acc && in_range && (in_data.row_in_page == 3'(r))),
      .wr_addr (in_data.byte_index[AW-1:0]),
      .wr_data (in_data.pixel_byte),
      .rd_en   (rd_en),
      .rd_addr (in_data.byte_index[AW-1:0]),
      .rd_data (rd_data[r])
    );
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_col_r <= in_data.byte_index;
      s1_pix_r <= in_data.pixel_byte;
    end
  end

  assign group.byte_index = s1_col_r;
  assign group.last_group = (s1_col_r == 4'(ROW_BYTES - 1));
  assign group.rows       = {s1_pix_r, rd_data};

  mbdp_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .invert     (invert_r),
    .load_valid (s1_valid_r),
    .load_ready (load_ready),
    .load_group (group),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  a_row7_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_valid_r)
    else $error("row-7 request lost before transpose");
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty stage");
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !load_ready |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_pix_r))
    else $error("waiting group changed");
  a_page_end_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_page |-> out_data.last_of_group)
    else $error("page end off a group end");
`endif

endmodule

>>> dv/tb_mono_bitmap_to_display_pages.sv
`timescale 1ns / 1ps

module tb_mono_bitmap_to_display_pages import mbdp_pkg::*; ();

  localparam int NUM_BYTES    = ROW_BYTES_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;

  class page_scoreboard;
    logic [7:0] rows_seen [STORED_ROWS][NUM_BYTES];
    bit         invert;
    mbdp_out_t  expected_q [$];
    int         errors;

    function new();
      invert = INVERT_RESET;
      errors = 0;
      foreach (rows_seen[r, b]) rows_seen[r][b] = '0;
    endfunction

    function void set_invert(bit v);
      invert = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Rows 0..6 only update the store; row 7 transposes the whole column group.
    function void note_request(mbdp_in_t d);
      logic [7:0] col_rows [PAGE_ROWS];
      mbdp_out_t  e;
      int         idx;
      idx = d.byte_index;
      if (idx >= NUM_BYTES) return;
      if (d.row_in_page != LAST_ROW) begin
        rows_seen[d.row_in_page][idx] = d.pixel_byte;
        return;
      end
      for (int r = 0; r < STORED_ROWS; r++) col_rows[r] = rows_seen[r][idx];
      col_rows[LAST_ROW] = d.pixel_byte;
      for (int k = 0; k < PIX_PER_BYTE; k++) begin
        e.column_index = 7'(idx * PIX_PER_BYTE + k);
        for (int r = 0; r < PAGE_ROWS; r++) e.page_byte[r] = col_rows[r][7 - k] ^ invert;
        e.last_of_group = (k == LAST_COLUMN);
        e.last_of_page  = (k == LAST_COLUMN) && (idx == NUM_BYTES - 1);
        expected_q.push_back(e);
      end
    endfunction

    function void check_result(mbdp_out_t a);
      mbdp_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected page byte: column_index %0d page_byte %h",
               a.column_index, a.page_byte);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.column_index !== e.column_index) begin
        $error("column_index: expected %0d, got %0d", e.column_index, a.column_index);
        errors++;
      end
      if (a.page_byte !== e.page_byte) begin
        $error("page_byte: expected %h, got %h", e.page_byte, a.page_byte);
        errors++;
      end
      if (a.last_of_group !== e.last_of_group) begin
        $error("last_of_group: expected %b, got %b", e.last_of_group, a.last_of_group);
        errors++;
      end
      if (a.last_of_page !== e.last_of_page) begin
        $error("last_of_page: expected %b, got %b", e.last_of_page, a.last_of_page);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  mbdp_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  mbdp_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  page_scoreboard sb;

  logic [STORED_ROWS-1:0] written [NUM_BYTES];
  int send_idle_pct;
  int recv_stall_pct;
  int sent_cnt;
  bit hold_req;
  bit hold_taken;
  int hold_left;
  int quiet_cycles;

  mono_bitmap_to_display_pages #(.ROW_BYTES(NUM_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results are checked before the request of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (cfg_valid && cfg_ready) sb.set_invert(cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_mono_bitmap_to_display_pages NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  task automatic send_req(input int row, input int idx, input logic [7:0] pix);
    mbdp_in_t d;
    d.row_in_page = 3'(row);
    d.byte_index  = 4'(idx);
    d.pixel_byte  = pix;
    @(negedge clk);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = d;
    do @(posedge clk); while (in_stall);
    if (row != LAST_ROW && idx < NUM_BYTES) written[idx][row] = 1'b1;
    sent_cnt++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_invert(input bit v);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly rewrites every row, sometimes leaves a stale one in place.
  task automatic send_group(input int idx);
    for (int r = 0; r < STORED_ROWS; r++) begin
      if (written[idx][r] != 1'b1 || $urandom_range(0, 5) != 0)
        send_req(r, idx, 8'($urandom));
    end
    send_req(LAST_ROW, idx, 8'($urandom));
  endtask

  task automatic send_noise();
    int idx;
    idx = $urandom_range(0, 15);
    if (idx < NUM_BYTES && written[idx] == '1 && $urandom_range(0, 1) == 1)
      send_req(LAST_ROW, idx, 8'($urandom));
    else if (idx >= NUM_BYTES)
      send_req($urandom_range(0, 7), idx, 8'($urandom));
    else
      send_req($urandom_range(0, STORED_ROWS - 1), idx, 8'($urandom));
  endtask

  task automatic run_phase(input int n);
    int start;
    int sel;
    start = sent_cnt;
    while (sent_cnt - start < n) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) send_group($urandom_range(0, NUM_BYTES - 1));
      else send_noise();
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_cnt       = 0;
    hold_req       = 1'b0;
    hold_taken     = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    foreach (written[i]) written[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: blank group, full group at the page end, diagonal, stale reuse.
    for (int r = 0; r < STORED_ROWS; r++) send_req(r, 0, 8'h00);
    send_req(LAST_ROW, 0, 8'h00);
    for (int r = 0; r < STORED_ROWS; r++) send_req(r, NUM_BYTES - 1, 8'hFF);
    send_req(LAST_ROW, NUM_BYTES - 1, 8'hFF);
    for (int r = 0; r < STORED_ROWS; r++) send_req(r, 5, 8'h80 >> r);
    send_req(LAST_ROW, 5, 8'h01);
    send_req(LAST_ROW, 0, 8'hAA);
    write_invert(1'b0);
    send_req(LAST_ROW, NUM_BYTES - 1, 8'h55);
    send_req(LAST_ROW, 5, 8'h80);

    // No idling, with one long receiver hold-off while requests keep coming.
    write_invert(1'b1);
    @(posedge clk);
    hold_req = 1'b1;
    run_phase(105);

    write_invert(1'b0);
    send_idle_pct  = 51;
    recv_stall_pct = 0;
    run_phase(105);

    write_invert(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    run_phase(105);

    write_invert(1'($urandom));
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    run_phase(105);

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb_mono_bitmap_to_display_pages OK");
    end else begin
      $display("tb_mono_bitmap_to_display_pages NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/mbdp_pkg.sv
design/mbdp_row_bank.sv
design/mbdp_burst.sv
design/mono_bitmap_to_display_pages.sv
dv/tb_mono_bitmap_to_display_pages.sv
